### hw/rtl/pra_pkg.sv
// Package for the binary PNM raster decoder: shared constants, codes and types.
// Depends on nothing; the front end, queue, divider, back end and top level import it.
package pra_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_FMT_W   = 3;
    localparam int CFG_SIZE_W  = 13;
    localparam int PIX_CNT_W   = 2 * CFG_SIZE_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = 8;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [31:0] PIX_BLACK    = 32'hff00_0000;
    localparam logic [31:0] PIX_WHITE    = 32'hffff_ffff;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_MAX_VALUE    = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef enum logic [CFG_FMT_W-1:0] {
        FMT_BITMAP    = 3'd0,
        FMT_GREY      = 3'd1,
        FMT_RGB       = 3'd2,
        FMT_PACKED332 = 3'd3,
        FMT_RGBA      = 3'd4
    } t_pixel_format;

    typedef enum logic [2:0] {
        JOB_BITMAP,
        JOB_GREY,
        JOB_PACKED,
        JOB_RGB,
        JOB_RGBA
    } t_job_kind;

    // Channel bytes are held in processing order, channel 0 first.
    typedef struct packed {
        t_job_kind       kind;
        logic [3:0][7:0] data;
        logic [3:0]      count;
        logic            last;
    } t_job;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_BITS,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic        start;
        logic [7:0]  sample;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } t_div_rsp;

    function automatic logic [7:0] widen3(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

endpackage

### hw/rtl/pra_byte_if.sv
// Stream interface carrying raster bytes into the decoder.
// Depends on nothing.
interface pra_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] raster_byte;

    modport source (output valid, output raster_byte, input ready);
    modport sink (input valid, input raster_byte, output ready);
endinterface

### hw/rtl/pra_pixel_if.sv
// Stream interface carrying ARGB pixels out of the decoder.
// Depends on nothing.
interface pra_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;
    logic        last_pixel;

    modport source (output valid, output pixel_argb, output last_pixel, input ready);
    modport sink (input valid, input pixel_argb, input last_pixel, output ready);
endinterface

### hw/rtl/pra_front.sv
// Front end of the decoder: configuration registers, byte gathering and pixel counting.
// Depends on pra_pkg and pra_byte_if; pushes one job per pixel group into the queue.
module pra_front import pra_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pra_byte_if.sink              i_byte,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job,
    output logic [15:0]           o_max_value
);

    logic [CFG_FMT_W-1:0]  r_fmt;
    logic [15:0]           r_max;
    logic [CFG_SIZE_W-1:0] r_width;
    logic [CFG_SIZE_W-1:0] r_height;
    logic [PIX_CNT_W-1:0]  r_total;
    logic [PIX_CNT_W-1:0]  n_total;
    logic                  r_settle;
    logic [PIX_CNT_W-1:0]  r_emitted;
    logic [1:0]            r_phase;
    logic [23:0]           r_gather;

    logic [CFG_SIZE_W-1:0] w_clamp;
    logic [CFG_SIZE_W-1:0] h_clamp;
    logic [PIX_CNT_W-1:0]  remaining;
    logic                  complete;
    logic                  accept;
    logic                  few;
    logic                  gather_load;
    logic                  phase_clr;
    logic [3:0]            adv;
    logic [7:0]            b;

    assign w_clamp = (r_width > MAX_WIDTH) ? CFG_SIZE_W'(MAX_WIDTH) : r_width;
    assign h_clamp = (r_height > MAX_HEIGHT) ? CFG_SIZE_W'(MAX_HEIGHT) : r_height;
    assign n_total = PIX_CNT_W'(w_clamp) * PIX_CNT_W'(h_clamp);

    assign remaining = r_total - r_emitted;
    assign complete  = r_emitted >= r_total;
    assign few       = remaining <= PIX_CNT_W'(8);
    assign b         = i_byte.raster_byte;

    assign i_byte.ready = !r_settle && !i_full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign o_max_value  = r_max;

    always_comb begin
        o_push      = 1'b0;
        o_job.kind  = JOB_GREY;
        o_job.data  = {24'h00_0000, b};
        o_job.count = 4'd1;
        o_job.last  = remaining == PIX_CNT_W'(1);
        gather_load = 1'b0;
        phase_clr   = 1'b0;
        adv         = 4'd0;
        if (accept && !complete) begin
            case (r_fmt)
                FMT_BITMAP: begin
                    o_push      = 1'b1;
                    o_job.kind  = JOB_BITMAP;
                    o_job.count = few ? remaining[3:0] : 4'd8;
                    o_job.last  = few;
                    adv         = o_job.count;
                end
                FMT_GREY: begin
                    o_push = 1'b1;
                    adv    = 4'd1;
                end
                FMT_PACKED332: begin
                    o_push     = 1'b1;
                    o_job.kind = JOB_PACKED;
                    adv        = 4'd1;
                end
                FMT_RGB: begin
                    if (r_phase < 2'd2) begin
                        gather_load = 1'b1;
                    end else begin
                        o_push     = 1'b1;
                        o_job.kind = JOB_RGB;
                        o_job.data = {8'h00, b, r_gather[7:0], r_gather[15:8]};
                        phase_clr  = 1'b1;
                        adv        = 4'd1;
                    end
                end
                FMT_RGBA: begin
                    if (r_phase < 2'd3) begin
                        gather_load = 1'b1;
                    end else begin
                        o_push     = 1'b1;
                        o_job.kind = JOB_RGBA;
                        o_job.data = {b, r_gather[7:0], r_gather[15:8], r_gather[23:16]};
                        phase_clr  = 1'b1;
                        adv        = 4'd1;
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_RGB;
            r_max     <= 16'd255;
            r_width   <= CFG_SIZE_W'(1);
            r_height  <= CFG_SIZE_W'(1);
            r_total   <= PIX_CNT_W'(1);
            r_settle  <= 1'b0;
            r_emitted <= '0;
            r_phase   <= 2'd0;
            r_gather  <= 24'h00_0000;
        end else begin
            r_total   <= n_total;
            r_settle  <= i_cfg_we;
            r_emitted <= r_emitted + PIX_CNT_W'(adv);
            if (gather_load) begin
                r_gather <= {r_gather[15:0], b};
                r_phase  <= r_phase + 2'd1;
            end else if (phase_clr) begin
                r_gather <= 24'h00_0000;
                r_phase  <= 2'd0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PIXEL_FORMAT: begin
                        r_fmt    <= i_cfg_data[CFG_FMT_W-1:0];
                        r_gather <= 24'h00_0000;
                        r_phase  <= 2'd0;
                    end
                    CFG_MAX_VALUE: begin
                        r_max <= i_cfg_data;
                    end
                    CFG_IMAGE_WIDTH: begin
                        r_width <= i_cfg_data[CFG_SIZE_W-1:0];
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_data[CFG_SIZE_W-1:0];
                    end
                    default: begin
                        r_max <= r_max;
                    end
                endcase
            end
        end
    end

endmodule

### hw/rtl/pra_job_fifo.sv
// Short job queue between the front and back ends of the decoder.
// Depends on pra_pkg for the job type and queue depth.
module pra_job_fifo import pra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr;
    logic [QUEUE_PTR_W-1:0] r_rptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/pra_scale_div.sv
// Iterative channel scaler: computes min(255, sample * 255 / divisor), one quotient bit a cycle.
// Depends on pra_pkg for the request and response types.
module pra_scale_div import pra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_steps;
    logic [15:0]          r_rem;
    logic [22:0]          r_dsh;
    logic [7:0]           r_quot;
    logic                 r_sat;

    logic [15:0] numer;
    logic        sat;
    logic        fits;

    assign numer = {i_req.sample, 8'h00} - {8'h00, i_req.sample};
    assign sat   = {8'h00, numer} >= {i_req.divisor, 8'h00};
    assign fits  = {7'h00, r_rem} >= r_dsh;

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_sat ? 8'hff : r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= numer;
            r_dsh  <= {i_req.divisor, 7'h00};
            r_quot <= 8'h00;
            r_sat  <= sat;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh[15:0];
            end
            r_quot <= {r_quot[6:0], fits};
            r_dsh  <= {1'b0, r_dsh[22:1]};
        end
    end

endmodule

### hw/rtl/pra_back.sv
// Back end of the decoder: takes jobs from the queue, scales channels and drives pixels.
// Depends on pra_pkg, pra_pixel_if and pra_scale_div.
module pra_back import pra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_empty,
    output logic        o_pop,
    input  logic [15:0] i_max_value,
    pra_pixel_if.source o_pixel
);

    t_back_state r_state;
    t_back_state n_state;
    t_job        r_job;
    logic [2:0]  r_idx;
    logic [7:0]  r_q [4];
    logic        r_out_valid;
    logic [31:0] r_out_pixel;
    logic        r_out_last;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic        slot_free;
    logic        bits_final;
    logic        chan_final;
    logic [2:0]  last_chan;
    logic        load;
    logic [31:0] load_pixel;
    logic        load_last;
    logic        idx_clr;
    logic        idx_inc;
    logic        q_wr;
    logic [31:0] assembled;

    pra_scale_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign slot_free  = !r_out_valid || o_pixel.ready;
    assign bits_final = ({1'b0, r_idx} + 4'd1) == r_job.count;
    assign chan_final = r_idx == last_chan;

    assign o_pixel.valid      = r_out_valid;
    assign o_pixel.pixel_argb = r_out_pixel;
    assign o_pixel.last_pixel = r_out_last;

    always_comb begin
        case (r_job.kind)
            JOB_RGB:  last_chan = 3'd2;
            JOB_RGBA: last_chan = 3'd3;
            default:  last_chan = 3'd0;
        endcase
    end

    always_comb begin
        case (r_job.kind)
            JOB_PACKED: begin
                assembled = {ALPHA_OPAQUE, widen3(r_job.data[0][7:5]),
                             widen3(r_job.data[0][4:2]), {4{r_job.data[0][1:0]}}};
            end
            JOB_RGB: begin
                assembled = {ALPHA_OPAQUE, r_q[0], r_q[1], r_q[2]};
            end
            JOB_RGBA: begin
                assembled = {r_q[3], r_q[0], r_q[1], r_q[2]};
            end
            default: begin
                assembled = {ALPHA_OPAQUE, r_q[0], r_q[0], r_q[0]};
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FETCH: begin
                if (!i_empty) begin
                    case (i_job.kind)
                        JOB_BITMAP: n_state = ST_BITS;
                        JOB_PACKED: n_state = ST_EMIT;
                        default:    n_state = ST_DIV_START;
                    endcase
                end
            end
            ST_BITS: begin
                if (slot_free && bits_final) begin
                    n_state = ST_FETCH;
                end
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = chan_final ? ST_EMIT : ST_DIV_START;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_FETCH;
                end
            end
            default: begin
                n_state = ST_FETCH;
            end
        endcase
    end

    always_comb begin
        o_pop           = 1'b0;
        div_req.start   = 1'b0;
        div_req.sample  = r_job.data[r_idx[1:0]];
        div_req.divisor = (i_max_value == 16'd0) ? 16'd1 : i_max_value;
        load            = 1'b0;
        load_pixel      = assembled;
        load_last       = r_job.last;
        idx_clr         = 1'b0;
        idx_inc         = 1'b0;
        q_wr            = 1'b0;
        case (r_state)
            ST_FETCH: begin
                o_pop   = !i_empty;
                idx_clr = 1'b1;
            end
            ST_BITS: begin
                if (slot_free) begin
                    load       = 1'b1;
                    load_pixel = r_job.data[0][3'd7 - r_idx] ? PIX_BLACK : PIX_WHITE;
                    load_last  = r_job.last && bits_final;
                    idx_inc    = 1'b1;
                end
            end
            ST_DIV_START: begin
                div_req.start = 1'b1;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    q_wr    = 1'b1;
                    idx_inc = !chan_final;
                end
            end
            ST_EMIT: begin
                load = slot_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (idx_clr) begin
                r_idx <= 3'd0;
            end else if (idx_inc) begin
                r_idx <= r_idx + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_pixel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (q_wr) begin
            r_q[r_idx[1:0]] <= div_rsp.quotient;
        end
        if (load) begin
            r_out_pixel <= load_pixel;
            r_out_last  <= load_last;
        end
    end

endmodule

### hw/rtl/pnm_raster_to_argb.sv
// Top level of the binary PNM raster decoder: raster bytes in, ARGB pixels out.
// Depends on pra_pkg, pra_byte_if, pra_pixel_if, pra_front, pra_job_fifo and pra_back.
//
// The front end takes one byte per cycle into a four-entry job queue when it has room,
// except in the cycle after a configuration write, when the byte port is held not ready
// while the pixel total is recomputed. The back end sets the sustained rate. A bitmap job
// is fetched and then gives one pixel per bit, fewer on the final byte of the image. A
// 3-3-2 byte is fetched and then emitted. Scaled channels go one at a time through a shared
// restoring divider: a grey, RGB or RGBA job is fetched, scaled and then emitted. An
// output register parts the back end from the pixel sink, so a waiting pixel transfer
// does not stop the queue from filling. The user writes configuration only while the
// block is idle, unenforced; writing the pixel format drops any partly gathered pixel.
module pnm_raster_to_argb import pra_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pra_byte_if.sink              i_byte,
    pra_pixel_if.source           o_pixel
);

    t_job        push_job;
    t_job        pop_job;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    logic [15:0] max_value;

    pra_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (i_byte),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job),
        .o_max_value (max_value)
    );

    pra_job_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    pra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (pop_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_max_value (max_value),
        .o_pixel     (o_pixel)
    );

endmodule
